// ----- hw/rtl/pitch_comb_pre_post_filter_defines.svh -----
// Assertion macros for the pitch comb filter checker.
// No dependencies; included by the checker only.
`ifndef PITCH_COMB_PRE_POST_FILTER_DEFINES_SVH
`define PITCH_COMB_PRE_POST_FILTER_DEFINES_SVH

// Checked while out of reset.
`define PCPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked in every cycle, reset included.
`define PCPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/pcpf_pkg.sv -----
// Shared constants for the pitch comb filter.
// No dependencies; used by the top level and the checker.
`default_nettype none
package pcpf_pkg;

  localparam int DELAY_DEPTH_DEF = 512;

  localparam logic [15:0] GAIN_BYPASS_BELOW = 16'd328;
  localparam logic [15:0] GAIN_UNITY        = 16'd32768;

  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

endpackage
`default_nettype wire

// ----- hw/rtl/pitch_comb_pre_post_filter.sv -----
// Pitch comb filter top level: delay memory, comb arithmetic, output register.
// Depends on pcpf_pkg and pcpf_ram.
//
//   channel | dir | handshake           | payload
//   in      | in  | in_valid / in_stall | sample_in, lag, comb_gain, frame_last
//   out     | out | out_valid/out_stall | sample_out, clipped, frame_end
//   cfg     | in  | cfg_we              | cfg_wdata (filter_mode)
//
// One item per cycle while the output is not stalled; accepted items go via stage b to the output register.
// Each item makes one delay-memory read (at accept) and one write (as it leaves stage b).
// A lag of one, in either filter mode, is served by forwarding the write in flight.
// Reset clears control only; no memory clear pass, a fill count masks unwritten slots.
// in_stall rises only while the output register is full and stalled.
`default_nettype none
module pitch_comb_pre_post_filter #(
  parameter int DELAY_DEPTH = pcpf_pkg::DELAY_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] sample_in,
  input  wire logic [9:0]         lag,
  input  wire logic [15:0]        comb_gain,
  input  wire logic               frame_last,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      sample_out,
  output logic                    clipped,
  output logic                    frame_end
);

  localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int CW = $clog2(DELAY_DEPTH + 1);
  localparam int LW = (CW > 10) ? CW : 10;
  localparam logic [LW-1:0] DEPTH_L   = LW'(DELAY_DEPTH);
  localparam logic [CW-1:0] DEPTH_C   = CW'(DELAY_DEPTH);
  localparam logic [CW:0]   DEPTH_X   = (CW+1)'(DELAY_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DELAY_DEPTH - 1);

  logic filter_mode;

  logic [AW-1:0] wp;
  logic [AW-1:0] wp_next;
  logic [CW-1:0] fill;

  // stage b: memory data arrives, arithmetic, write back
  logic               b_valid;
  logic signed [15:0] b_x;
  logic [15:0]        b_gain;
  logic               b_bypass;
  logic               b_last;
  logic               b_dvalid;
  logic               b_hit;
  logic [15:0]        b_fwd;
  logic [AW-1:0]      b_waddr;

  logic          accept;
  logic          b_adv;
  logic [LW-1:0] lag_ext;
  logic [CW-1:0] lag_c;
  logic [CW:0]   wp_x;
  logic [CW:0]   lag_x;
  logic [CW:0]   rd_full;
  logic [AW-1:0] rd_addr;
  logic [15:0]   gain_c;
  logic          bypass;

  logic [15:0]        ram_q;
  logic signed [15:0] d;
  logic signed [32:0] prod;
  logic signed [32:0] biased;
  logic signed [17:0] r;
  logic signed [18:0] s;
  logic signed [15:0] y;
  logic               clip;
  logic [15:0]        wdata;

  assign b_adv    = !out_valid || !out_stall;
  assign in_stall = b_valid && !b_adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    lag_ext = LW'(lag);
    lag_c   = (lag_ext > DEPTH_L) ? DEPTH_C : CW'(lag_ext);
    wp_x    = (CW+1)'(wp);
    lag_x   = (CW+1)'(lag_c);
    rd_full = (lag_x > wp_x) ? (wp_x + DEPTH_X - lag_x) : (wp_x - lag_x);
    rd_addr = rd_full[AW-1:0];
    gain_c  = (comb_gain > pcpf_pkg::GAIN_UNITY) ? pcpf_pkg::GAIN_UNITY : comb_gain;
    bypass  = (lag == 10'd0) || (comb_gain < pcpf_pkg::GAIN_BYPASS_BELOW);
    wp_next = (wp == LAST_SLOT) ? '0 : wp + AW'(1);
  end

  pcpf_ram #(
    .WIDTH (16),
    .DEPTH (DELAY_DEPTH),
    .AW    (AW)
  ) u_hist (
    .clk   (clk),
    .we    (b_valid && b_adv),
    .waddr (b_waddr),
    .wdata (wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_comb begin
    priority if (!b_dvalid) begin
      d = '0;
    end else if (b_hit) begin
      d = $signed(b_fwd);
    end else begin
      d = $signed(ram_q);
    end
    prod   = $signed({1'b0, b_gain}) * d;
    biased = prod + 33'sd16384;
    r      = biased[32:15];
    if (filter_mode == pcpf_pkg::MODE_DEC) begin
      s = {{3{b_x[15]}}, b_x} + {r[17], r};
    end else begin
      s = {{3{b_x[15]}}, b_x} - {r[17], r};
    end
    clip = 1'b0;
    priority if (b_bypass) begin
      y = b_x;
    end else if (s > 19'sd32767) begin
      y    = pcpf_pkg::SAMPLE_MAX;
      clip = 1'b1;
    end else if (s < -19'sd32768) begin
      y    = pcpf_pkg::SAMPLE_MIN;
      clip = 1'b1;
    end else begin
      y = s[15:0];
    end
    wdata = (filter_mode == pcpf_pkg::MODE_DEC) ? y : b_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= pcpf_pkg::MODE_ENC;
      wp          <= '0;
      fill        <= '0;
      b_valid     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        filter_mode <= cfg_wdata;
      end
      if (accept) begin
        wp <= wp_next;
        if (fill != DEPTH_C) begin
          fill <= fill + CW'(1);
        end
      end
      if (accept) begin
        b_valid <= 1'b1;
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
      if (b_valid && b_adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_x      <= sample_in;
      b_gain   <= gain_c;
      b_bypass <= bypass;
      b_last   <= frame_last;
      b_dvalid <= (fill >= lag_c);
      // previous item is writing this very slot in the same cycle
      b_hit    <= b_valid && b_adv && (b_waddr == rd_addr);
      b_fwd    <= wdata;
      b_waddr  <= wp;
    end
    if (b_valid && b_adv) begin
      sample_out <= y;
      clipped    <= clip;
      frame_end  <= b_last;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/pcpf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module pcpf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/pcpf_chk.sv -----
// Port-level checker for the pitch comb filter, bound to the top level.
// Depends on pcpf_pkg and pitch_comb_pre_post_filter_defines.svh.
`default_nettype none
`include "pitch_comb_pre_post_filter_defines.svh"
module pcpf_chk (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [15:0] sample_out,
  input wire logic               clipped,
  input wire logic               frame_end
);

  `PCPF_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "output item dropped while stalled")
  `PCPF_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(sample_out) && $stable(clipped) && $stable(frame_end), "stalled output item changed")
  `PCPF_ASSERT(a_clip_value, out_valid && clipped |-> sample_out == pcpf_pkg::SAMPLE_MAX || sample_out == pcpf_pkg::SAMPLE_MIN, "clipped item not at a rail")
  `PCPF_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled with output free")
  `PCPF_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid right after reset")

endmodule

bind pitch_comb_pre_post_filter pcpf_chk u_pcpf_chk (.*);
`default_nettype wire

// ----- bench/tb_pitch_comb_pre_post_filter.sv -----
// Testbench for pitch_comb_pre_post_filter: directed corner items, then framed random
// traffic in both filter modes under random input/output stalls, checked by a scoreboard.
// Depends on pcpf_pkg and the pitch_comb_pre_post_filter RTL.
module tb_pitch_comb_pre_post_filter;

  localparam int DEPTH      = pcpf_pkg::DELAY_DEPTH_DEF;
  localparam int FRAC_BITS  = 15;
  localparam int ROUND_HALF = 16384;
  localparam int LIMIT      = 400000;
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 205;
  localparam int LONG_HOLD  = 300;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               clip;
    logic               last;
  } comb_result_t;

  class comb_scoreboard;
    logic signed [15:0] delay_line [DEPTH];
    int unsigned        wr_ptr;
    logic               dec_mode;
    comb_result_t       expected_q[$];
    int                 errors;

    function new();
      foreach (delay_line[i]) delay_line[i] = '0;
      wr_ptr   = 0;
      dec_mode = pcpf_pkg::MODE_ENC;
      errors   = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Comb filter step for one accepted item; updates the delay line.
    function void note_sample(logic signed [15:0] x, logic [9:0] lag_i,
                              logic [15:0] gain_i, logic fl);
      int unsigned  l;
      int unsigned  g;
      int unsigned  rd;
      longint       prod;
      longint       rnd;
      longint       s;
      comb_result_t e;
      l = (lag_i > DEPTH) ? DEPTH : lag_i;
      g = (gain_i > pcpf_pkg::GAIN_UNITY) ? pcpf_pkg::GAIN_UNITY : gain_i;
      e.sample = x;
      e.clip   = 1'b0;
      e.last   = fl;
      if (l != 0 && g >= pcpf_pkg::GAIN_BYPASS_BELOW) begin
        rd   = (wr_ptr + DEPTH - l) % DEPTH;
        prod = longint'(g) * longint'(delay_line[rd]);
        rnd  = (prod + ROUND_HALF) >>> FRAC_BITS;
        s    = (dec_mode == pcpf_pkg::MODE_DEC) ? longint'(x) + rnd : longint'(x) - rnd;
        if (s > pcpf_pkg::SAMPLE_MAX) begin
          e.sample = pcpf_pkg::SAMPLE_MAX;
          e.clip   = 1'b1;
        end else if (s < pcpf_pkg::SAMPLE_MIN) begin
          e.sample = pcpf_pkg::SAMPLE_MIN;
          e.clip   = 1'b1;
        end else begin
          e.sample = 16'(s);
        end
      end
      delay_line[wr_ptr] = (dec_mode == pcpf_pkg::MODE_DEC) ? e.sample : x;
      wr_ptr = (wr_ptr + 1) % DEPTH;
      expected_q.push_back(e);
    endfunction

    function void check_result(logic signed [15:0] s, logic c, logic f);
      comb_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected item, sample_out %0d clipped %0b frame_end %0b",
                 $time, s, c, f);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (s !== e.sample) begin
        $display("%0t: sample_out expected %0d actual %0d", $time, e.sample, s);
        errors++;
      end
      if (c !== e.clip) begin
        $display("%0t: clipped expected %0b actual %0b", $time, e.clip, c);
        errors++;
      end
      if (f !== e.last) begin
        $display("%0t: frame_end expected %0b actual %0b", $time, e.last, f);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic               cfg_wdata = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] sample_in = '0;
  logic [9:0]         lag = '0;
  logic [15:0]        comb_gain = '0;
  logic               frame_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] sample_out;
  logic               clipped;
  logic               frame_end;

  comb_scoreboard sb;
  bit             quiet = 1'b0;
  bit             long_hold_req = 1'b0;
  int             hold_left = 0;
  int             stall_left = 0;
  int             cycle_count = 0;

  pitch_comb_pre_post_filter #(.DELAY_DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .lag        (lag),
    .comb_gain  (comb_gain),
    .frame_last (frame_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .clipped    (clipped),
    .frame_end  (frame_end)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Output side: random stall bursts, plus one long hold on request.
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(sample_out, clipped, frame_end);
  end

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic send_item(logic signed [15:0] x, logic [9:0] l, logic [15:0] g, logic fl);
    if (!quiet && $urandom_range(0, 5) == 0) idle_cycles($urandom_range(1, 8));
    @(negedge clk);
    in_valid   <= 1'b1;
    sample_in  <= x;
    lag        <= l;
    comb_gain  <= g;
    frame_last <= fl;
    do @(posedge clk); while (in_stall);
    sb.note_sample(x, l, g, fl);
  endtask

  task automatic wait_drained();
    idle_cycles(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.dec_mode = m;
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return pcpf_pkg::SAMPLE_MAX;
      1:       return pcpf_pkg::SAMPLE_MIN;
      2:       return 16'($signed($urandom_range(0, 511)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [9:0] pick_lag();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return 10'd0;
    if (r == 2) return 10'($urandom_range(DEPTH + 1, 1023));
    if (r < 8) return 10'($urandom_range(1, 8));
    if (r == 8) return 10'(DEPTH);
    return 10'($urandom_range(1, DEPTH));
  endfunction

  function automatic logic [15:0] pick_gain();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return 16'($urandom_range(0, pcpf_pkg::GAIN_BYPASS_BELOW - 1));
    if (r == 2) return 16'($urandom_range(pcpf_pkg::GAIN_UNITY + 1, 65535));
    if (r < 5) return pcpf_pkg::GAIN_UNITY;
    return 16'($urandom_range(pcpf_pkg::GAIN_BYPASS_BELOW, pcpf_pkg::GAIN_UNITY - 1));
  endfunction

  // Each frame keeps one lag and gain; a few items are pure noise.
  task automatic run_frames(int n);
    int          left;
    int          frame_len;
    logic [9:0]  f_lag;
    logic [15:0] f_gain;
    left = n;
    while (left > 0) begin
      frame_len = $urandom_range(4, 40);
      f_lag     = pick_lag();
      f_gain    = pick_gain();
      for (int k = 0; k < frame_len && left > 0; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(16'($urandom), 10'($urandom), 16'($urandom), 1'($urandom));
        else
          send_item(pick_sample(), f_lag, f_gain, k == frame_len - 1);
        left--;
      end
    end
  endtask

  initial begin
    int drain;
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // encoder corners
    write_mode(pcpf_pkg::MODE_ENC);
    send_item(pcpf_pkg::SAMPLE_MAX, 10'd0, pcpf_pkg::GAIN_UNITY, 1'b0);
    send_item(pcpf_pkg::SAMPLE_MIN, 10'd1, 16'd327, 1'b0);
    send_item(16'sd1000, 10'd1, pcpf_pkg::GAIN_BYPASS_BELOW, 1'b0);
    send_item(pcpf_pkg::SAMPLE_MAX, 10'd2, pcpf_pkg::GAIN_UNITY, 1'b0);
    send_item(pcpf_pkg::SAMPLE_MIN, 10'd1, 16'hffff, 1'b0);
    send_item(16'sd0, 10'(DEPTH), pcpf_pkg::GAIN_UNITY, 1'b0);
    send_item(-16'sd1, 10'h3ff, 16'd16384, 1'b1);
    send_item(16'sd12345, 10'(DEPTH + 1), 16'd40000, 1'b0);
    wait_drained();

    // decoder corners, including lag-one feedback on consecutive items
    write_mode(pcpf_pkg::MODE_DEC);
    send_item(pcpf_pkg::SAMPLE_MAX, 10'd0, 16'd0, 1'b0);
    send_item(pcpf_pkg::SAMPLE_MAX, 10'd1, pcpf_pkg::GAIN_UNITY, 1'b0);
    send_item(pcpf_pkg::SAMPLE_MIN, 10'd1, pcpf_pkg::GAIN_UNITY, 1'b0);
    send_item(pcpf_pkg::SAMPLE_MIN, 10'd0, pcpf_pkg::GAIN_UNITY, 1'b0);
    send_item(pcpf_pkg::SAMPLE_MIN, 10'd1, pcpf_pkg::GAIN_UNITY, 1'b0);
    send_item(-16'sd1, 10'(DEPTH), 16'd40000, 1'b1);
    send_item(16'sd12345, 10'd1, 16'd1000, 1'b0);
    send_item(-16'sd2222, 10'd1, 16'd30000, 1'b0);
    send_item(16'sd5, 10'd2, 16'd327, 1'b1);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) quiet = 1'b1;
      write_mode((p % 2 == 0) ? pcpf_pkg::MODE_ENC : pcpf_pkg::MODE_DEC);
      if (p == 1) long_hold_req = 1'b1;
      run_frames(PHASE_LEN);
      wait_drained();
    end

    drain = 0;
    while (sb.pending() != 0 && drain < 1000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0t: %0d expected items never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/pcpf_pkg.sv
hw/rtl/pcpf_ram.sv
hw/rtl/pitch_comb_pre_post_filter.sv
hw/rtl/pcpf_chk.sv
bench/tb_pitch_comb_pre_post_filter.sv
